/* rtl/rrjq_pkg.sv */
// Shared types, constants and helpers for the round-robin job queue.
// No dependencies; imported by every module of the block.
package rrjq_pkg;

   localparam int QueueDepth  = 8;
   localparam int IdxWidth    = $clog2(QueueDepth);
   localparam int OccWidth    = $clog2(QueueDepth + 1);
   localparam int SumWidth    = OccWidth + 1;
   localparam int TimeWidth   = 32;
   localparam int LenWidth    = 3;
   localparam int JobIdWidth  = 3;
   localparam int AddrWidth   = 3;
   localparam int DataWidth   = 32;

   localparam logic [LenWidth-1:0]  QuantumReset   = LenWidth'(2);
   localparam logic [TimeWidth-1:0] GapThreshReset = TimeWidth'(5);

   typedef enum logic [1:0] {
      KIND_SLICE  = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_DROP   = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      REG_QUANTUM  = 1'b0,
      REG_GAP      = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_DRAIN,
      STATE_FINAL
   } state_type;

   typedef struct packed {
      logic [TimeWidth-1:0] arrival_time;
      logic [LenWidth-1:0]  run_length;
   } req_item_type;

   typedef struct packed {
      kind_type              kind;
      logic [JobIdWidth-1:0] job_id;
      logic [LenWidth-1:0]   slice_length;
      logic                  last;
   } rsp_item_type;

   typedef struct packed {
      logic [JobIdWidth-1:0] id;
      logic [LenWidth-1:0]   remaining;
   } slot_type;

   // ring index base + step, step never above QueueDepth
   function automatic logic [IdxWidth-1:0] ring_add(input logic [IdxWidth-1:0] base,
                                                    input logic [OccWidth-1:0] step);
      logic [SumWidth-1:0] sum;
      sum = SumWidth'(base) + SumWidth'(step);
      if (sum >= SumWidth'(QueueDepth)) begin
         sum = sum - SumWidth'(QueueDepth);
      end
      return sum[IdxWidth-1:0];
   endfunction

endpackage

/* rtl/round_robin_job_queue_core.sv */
// Top level of the round-robin job queue: sequencer, output register, assertions.
// Depends on rrjq_pkg, rrjq_csr, rrjq_slot_store, rrjq_slice_unit.
//
//  channel | ports      | direction | moves
//  --------+------------+-----------+---------------------------------------
//  req     | req_*      | in        | job arrival item (time, run length)
//  rsp     | rsp_*      | out       | slice, accept or drop item
//  csr     | csr_*      | in/out    | quantum, gap threshold
//
// An arrival moves from idle through an optional drain, one slice item at a time,
// to the accept or drop item; the slice unit sizes each slice.
// A drain gives each queued job ceil(run / quantum) slices, one for a zero-length
// job, so at most 56 slices.
// rsp_stall holds the sequencer at the output register; req_stall is high
// while an item is in progress. Reset empties the queue and restores registers.
module round_robin_job_queue_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rrjq_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rrjq_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rrjq_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [rrjq_pkg::DataWidth-1:0]   csr_pwdata,
   output logic [rrjq_pkg::DataWidth-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import rrjq_pkg::*;

   logic [LenWidth-1:0]  quantum;
   logic [TimeWidth-1:0] gap_threshold;

   state_type            state_ff,   state_in;
   logic [IdxWidth-1:0]  head_ff,    head_in;
   logic [OccWidth-1:0]  occ_ff,     occ_in;
   logic [TimeWidth-1:0] tail_arr_ff, tail_arr_in;
   logic [TimeWidth-1:0] arr_ff,     arr_in;
   logic [LenWidth-1:0]  len_ff,     len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff,  rsp_item_in;

   logic                 out_free;
   logic                 load_out;
   logic                 wr_en;
   logic [IdxWidth-1:0]  wr_idx;
   slot_type             wr_data;
   slot_type             head_slot;
   logic [LenWidth-1:0]  run;
   logic [LenWidth-1:0]  left;
   logic [TimeWidth-1:0] gap;
   logic                 queue_full;

   rrjq_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .quantum       (quantum),
      .gap_threshold (gap_threshold)
   );

   rrjq_slot_store u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (head_in),
      .rd_data (head_slot)
   );

   rrjq_slice_unit u_slice (
      .remaining (head_slot.remaining),
      .quantum   (quantum),
      .run       (run),
      .left      (left)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != STATE_IDLE);
   assign gap        = req_item.arrival_time - tail_arr_ff;
   assign queue_full = (occ_ff == OccWidth'(QueueDepth));

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      occ_in      = occ_ff;
      tail_arr_in = tail_arr_ff;
      arr_in      = arr_ff;
      len_in      = len_ff;
      rsp_item_in = rsp_item_ff;
      load_out    = 1'b0;
      wr_en       = 1'b0;
      wr_idx      = ring_add(head_ff, occ_ff);
      wr_data     = '{id: head_slot.id, remaining: left};
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               arr_in = req_item.arrival_time;
               len_in = req_item.run_length;
               if ((occ_ff != '0) && (gap > gap_threshold)) begin
                  state_in = STATE_DRAIN;
               end else begin
                  state_in = STATE_FINAL;
               end
            end
         end
         STATE_DRAIN: begin
            if (out_free) begin
               load_out    = 1'b1;
               rsp_item_in = '{kind: KIND_SLICE, job_id: head_slot.id,
                               slice_length: run, last: 1'b0};
               head_in     = ring_add(head_ff, OccWidth'(1));
               if (left != '0) begin
                  wr_en = 1'b1;
               end else begin
                  occ_in = occ_ff - OccWidth'(1);
                  if (occ_ff == OccWidth'(1)) begin
                     head_in  = '0;
                     state_in = STATE_FINAL;
                  end
               end
            end
         end
         STATE_FINAL: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = STATE_IDLE;
               if (queue_full) begin
                  rsp_item_in = '{kind: KIND_DROP, job_id: '0,
                                  slice_length: '0, last: 1'b1};
               end else begin
                  wr_en       = 1'b1;
                  wr_data     = '{id: JobIdWidth'(occ_ff), remaining: len_ff};
                  tail_arr_in = arr_ff;
                  occ_in      = occ_ff + OccWidth'(1);
                  rsp_item_in = '{kind: KIND_ACCEPT, job_id: JobIdWidth'(occ_ff),
                                  slice_length: '0, last: 1'b1};
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_arr_ff <= tail_arr_in;
      arr_ff      <= arr_in;
      len_ff      <= len_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OccWidth'(QueueDepth))
      else $error("occupancy above queue depth");

   a_idle_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_IDLE |-> head_ff == '0)
      else $error("head not at slot zero between items");

   a_accept_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_FINAL && out_free && !queue_full)
      |=> occ_ff == $past(occ_ff) + OccWidth'(1))
      else $error("accepted job not counted");

   a_slice_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.kind == KIND_SLICE |-> !rsp_item_ff.last)
      else $error("slice item flagged last");

endmodule

/* rtl/rrjq_slot_store.sv */
// Ring of job slots (id and remaining time), one write and one registered read port.
// Depends on rrjq_pkg.
module rrjq_slot_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [rrjq_pkg::IdxWidth-1:0]    wr_idx,
   input  rrjq_pkg::slot_type               wr_data,
   input  logic [rrjq_pkg::IdxWidth-1:0]    rd_idx,
   output rrjq_pkg::slot_type               rd_data
);
   import rrjq_pkg::*;

   slot_type slots_ff [QueueDepth];
   slot_type rd_data_ff;

   // read data follows a write to the same slot in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_idx] <= wr_data;
      end
      if (wr_en && (wr_idx == rd_idx)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= slots_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rrjq_slice_unit.sv */
// Slice unit: run = min(remaining, max(quantum, 1)) and the time left after it.
// Depends on rrjq_pkg.
module rrjq_slice_unit (
   input  logic [rrjq_pkg::LenWidth-1:0] remaining,
   input  logic [rrjq_pkg::LenWidth-1:0] quantum,
   output logic [rrjq_pkg::LenWidth-1:0] run,
   output logic [rrjq_pkg::LenWidth-1:0] left
);
   import rrjq_pkg::*;

   logic [LenWidth-1:0] q_eff;

   always_comb begin
      q_eff = (quantum == '0) ? LenWidth'(1) : quantum;
      run   = (remaining < q_eff) ? remaining : q_eff;
      left  = remaining - run;
   end

endmodule

/* rtl/rrjq_csr.sv */
// APB-style register file: quantum and gap threshold.
// Depends on rrjq_pkg.
module rrjq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rrjq_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [rrjq_pkg::DataWidth-1:0]   csr_pwdata,
   output logic [rrjq_pkg::DataWidth-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [rrjq_pkg::LenWidth-1:0]    quantum,
   output logic [rrjq_pkg::TimeWidth-1:0]   gap_threshold
);
   import rrjq_pkg::*;

   logic [LenWidth-1:0]  quantum_ff,  quantum_in;
   logic [TimeWidth-1:0] gap_ff,      gap_in;
   reg_index_type        reg_sel;
   logic                 wr_fire;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      quantum_in = quantum_ff;
      gap_in     = gap_ff;
      csr_prdata = '0;
      case (reg_sel)
         REG_QUANTUM: begin
            if (wr_fire) quantum_in = csr_pwdata[LenWidth-1:0];
            csr_prdata = DataWidth'(quantum_ff);
         end
         REG_GAP: begin
            if (wr_fire) gap_in = csr_pwdata[TimeWidth-1:0];
            csr_prdata = DataWidth'(gap_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QuantumReset;
         gap_ff     <= GapThreshReset;
      end else begin
         quantum_ff <= quantum_in;
         gap_ff     <= gap_in;
      end
   end

   assign quantum       = quantum_ff;
   assign gap_threshold = gap_ff;

endmodule
